// ===== rtl/core/pef_pkg.sv =====
// shared types, constants and colour helpers for the palette entry fader
// used by every file under rtl/core; no dependencies
package pef_pkg;

  localparam int NUM_ENTRIES = 24;
  localparam int CNT_W       = $clog2(NUM_ENTRIES + 1);
  localparam int IDX_W       = 5;
  localparam int TICKS_W     = 8;
  localparam logic [TICKS_W-1:0] FADE_TICKS = TICKS_W'(8'h80);

  typedef enum logic [1:0] {
    OP_LOAD  = 2'd0,
    OP_START = 2'd1,
    OP_TICK  = 2'd2
  } op_t;

  typedef struct packed {
    logic [1:0]       op;
    logic [IDX_W-1:0] entry_index;
    logic [15:0]      current_colour;
    logic [15:0]      next_colour;
  } in_word_t;

  typedef struct packed {
    logic [IDX_W-1:0] out_index;
    logic [14:0]      colour;
    logic             last;
    logic             fade_done;
  } out_word_t;

  typedef logic [2:0][15:0] chan_t;

  typedef struct packed {
    chan_t value;
    chan_t step;
  } cell_data_t;

  // channel ch goes to bits 14:10 of its accumulator
  function automatic chan_t unpack_colour(input logic [15:0] c);
    chan_t r;
    for (int ch = 0; ch < 3; ch++) begin
      r[ch] = {1'b0, c[4*ch +: 4], c[12+ch], 10'b0};
    end
    return r;
  endfunction

  // (target - present) >> 7, arithmetic, 16-bit wrap
  function automatic chan_t make_step(input chan_t cur, input chan_t nxt);
    chan_t       s;
    logic [15:0] d;
    for (int ch = 0; ch < 3; ch++) begin
      d     = nxt[ch] - cur[ch];
      s[ch] = {{7{d[15]}}, d[15:7]};
    end
    return s;
  endfunction

  function automatic logic [14:0] repack(input chan_t v);
    logic [14:0] o;
    o = '0;
    for (int ch = 0; ch < 3; ch++) begin
      o[4*ch +: 4] = v[ch][14:11];
      o[12+ch]     = v[ch][10];
    end
    return o;
  endfunction

endpackage

// ===== rtl/core/pef_cell.sv =====
// one cell of the entry ring: holds values and steps of one palette entry
// depends on pef_pkg
module pef_cell (
  input  logic                clk,
  input  logic                load_en,
  input  pef_pkg::cell_data_t load_data,
  input  logic                shift_en,
  input  pef_pkg::cell_data_t shift_in,
  output pef_pkg::cell_data_t data_q
);

  pef_pkg::cell_data_t data_r;
  pef_pkg::cell_data_t data_nxt;

  always_comb begin
    data_nxt = data_r;
    if (load_en) begin
      data_nxt = load_data;
    end else if (shift_en) begin
      data_nxt = shift_in;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign data_q = data_r;

endmodule

// ===== rtl/core/pef_fade_unit.sv =====
// per-entry fade step: adds the steps to the channel values and repacks
// depends on pef_pkg
module pef_fade_unit (
  input  pef_pkg::cell_data_t head,
  output pef_pkg::cell_data_t updated,
  output logic [14:0]         colour
);

  pef_pkg::chan_t sum;

  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      sum[ch] = head.value[ch] + head.step[ch];
    end
  end

  assign updated.value = sum;
  assign updated.step  = head.step;
  assign colour        = pef_pkg::repack(sum);

endmodule

// ===== rtl/core/palette_entry_linear_fader.sv =====
// top level of the palette entry fader: ring of entry cells, fade unit, control
// depends on pef_pkg, pef_cell, pef_fade_unit
//
// output: an armed tick sets busy_r; each word is then registered in word_r and
//   strobe_r, one word per cycle, NUM_ENTRIES words in all
// throughput: a tick holds busy for one ring rotation through the single fade unit;
//   loads and starts are taken every cycle while busy is low
// reset: synchronous active-low rst_n clears the countdown, busy and the strobe;
//   entry storage is not cleared and holds garbage until loaded
// the receiver cannot stall: each word is strobed on out_word for exactly one cycle
module palette_entry_linear_fader (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  pef_pkg::in_word_t   in_word,
  output logic                out_strobe,
  output pef_pkg::out_word_t  out_word
);

  localparam int N = pef_pkg::NUM_ENTRIES;

  // control registers
  logic                          busy_r,   busy_nxt;
  logic [pef_pkg::CNT_W-1:0]     cnt_r,    cnt_nxt;
  logic [pef_pkg::TICKS_W-1:0]   ticks_r,  ticks_nxt;
  logic                          done_r,   done_nxt;
  logic                          strobe_r, strobe_nxt;
  pef_pkg::out_word_t            word_r,   word_nxt;

  // item handshake
  logic accept;
  logic is_load;
  logic is_start;
  logic is_tick;
  assign accept   = start && !busy_r;
  assign is_load  = accept && (in_word.op == pef_pkg::OP_LOAD);
  assign is_start = accept && (in_word.op == pef_pkg::OP_START);
  assign is_tick  = accept && (in_word.op == pef_pkg::OP_TICK);

  logic cnt_last;
  assign cnt_last = (cnt_r == pef_pkg::CNT_W'(N - 1));

  // load data unpacked once, broadcast to every cell
  pef_pkg::cell_data_t load_data;
  always_comb begin
    load_data.value = pef_pkg::unpack_colour(in_word.current_colour);
    load_data.step  = pef_pkg::make_step(load_data.value,
                                         pef_pkg::unpack_colour(in_word.next_colour));
  end

  // ring of cells: cell k takes from cell k+1, the tail takes the updated head
  pef_pkg::cell_data_t cell_q [N];
  pef_pkg::cell_data_t updated;
  logic [14:0]         colour;

  for (genvar k = 0; k < N; k++) begin : g_cell
    pef_pkg::cell_data_t ring_in;
    logic                sel;

    // out-of-range indexes match no cell and are dropped
    assign sel = is_load && (int'(in_word.entry_index) == k);

    if (k == N - 1) begin : g_tail
      assign ring_in = updated;
    end else begin : g_mid
      assign ring_in = cell_q[k+1];
    end

    pef_cell u_cell (
      .clk       (clk),
      .load_en   (sel),
      .load_data (load_data),
      .shift_en  (busy_r),
      .shift_in  (ring_in),
      .data_q    (cell_q[k])
    );
  end

  // head cell always holds the entry whose turn it is
  pef_fade_unit u_fade (
    .head    (cell_q[0]),
    .updated (updated),
    .colour  (colour)
  );

  always_comb begin
    busy_nxt   = busy_r;
    cnt_nxt    = cnt_r;
    ticks_nxt  = ticks_r;
    done_nxt   = done_r;
    strobe_nxt = busy_r;
    word_nxt   = word_r;

    if (is_start) begin
      ticks_nxt = pef_pkg::FADE_TICKS;
    end

    // idle tick (countdown at zero) does nothing
    if (is_tick && (ticks_r != '0)) begin
      ticks_nxt = ticks_r - pef_pkg::TICKS_W'(1);
      done_nxt  = (ticks_r == pef_pkg::TICKS_W'(1));
      busy_nxt  = 1'b1;
      cnt_nxt   = '0;
    end

    // one entry per cycle while the ring rotates
    if (busy_r) begin
      word_nxt.out_index = pef_pkg::IDX_W'(cnt_r);
      word_nxt.colour    = colour;
      word_nxt.last      = cnt_last;
      word_nxt.fade_done = done_r;
      cnt_nxt            = cnt_r + pef_pkg::CNT_W'(1);
      if (cnt_last) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r   <= 1'b0;
      cnt_r    <= '0;
      ticks_r  <= '0;
      done_r   <= 1'b0;
      strobe_r <= 1'b0;
    end else begin
      busy_r   <= busy_nxt;
      cnt_r    <= cnt_nxt;
      ticks_r  <= ticks_nxt;
      done_r   <= done_nxt;
      strobe_r <= strobe_nxt;
    end
  end

  // payload register, no reset needed
  always_ff @(posedge clk) begin
    word_r <= word_nxt;
  end

  assign busy       = busy_r;
  assign out_strobe = strobe_r;
  assign out_word   = word_r;

  // a word only follows a busy cycle
  a_strobe_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    strobe_r |-> $past(busy_r))
    else $error("word strobed without a rotation cycle");

  // a rotation only starts with the countdown armed
  a_rotate_armed: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(busy_r) |-> ($past(ticks_r) != '0))
    else $error("rotation started with no fade armed");

  // the end of a rotation is marked by the last word
  a_fall_last: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(busy_r) |-> (strobe_r && word_r.last))
    else $error("rotation ended without a last word");

  // last word never comes while the ring is still turning
  a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (strobe_r && word_r.last) |-> !busy_r)
    else $error("last word while still busy");

endmodule

// ===== sim/testbench.sv =====
// self-checking testbench for palette_entry_linear_fader: command-style stimulus,
// an in-bench fade predictor and a word-by-word checker of the result stream
// depends on pef_pkg and the palette_entry_linear_fader top level
module testbench;
  import pef_pkg::*;

  // op code the block leaves unused; it must be ignored
  localparam logic [1:0] OP_SPARE = 2'd3;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      start = 1'b0;
  logic      busy;
  in_word_t  in_word = '0;
  logic      out_strobe;
  out_word_t out_word;

  palette_entry_linear_fader u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_word    (in_word),
    .out_strobe (out_strobe),
    .out_word   (out_word)
  );

  always #10 clk = ~clk;

  // pending command words, filled once by the stimulus block
  in_word_t  cmd_q[$];
  // faded colour words the block still owes us, oldest first
  out_word_t faded_q[$];

  // predictor state: per-entry channel accumulators and steps, plus countdown
  chan_t      acc_value [NUM_ENTRIES];
  chan_t      acc_incr  [NUM_ENTRIES];
  logic [7:0] fade_left = '0;

  int mismatches = 0;
  int n_loads = 0, n_starts = 0, n_armed_ticks = 0, n_fades = 0, n_words = 0;
  bit took = 1'b0;     // a word was accepted at the last rising edge
  int gap_left = 0;    // remaining cycles of the current idle burst
  int idle_pct = 20;   // chance of opening an idle burst, toggled to zero now and then

  // packed colour -> three accumulators, channel value in bits 14:10
  function automatic chan_t colour_to_acc(input logic [15:0] c);
    chan_t r;
    for (int ch = 0; ch < 3; ch++) begin
      r[ch] = (16'(c[4*ch +: 4]) << 11) | (16'(c[12+ch]) << 10);
    end
    return r;
  endfunction

  // per-channel increment: difference over 128, sign kept, 16-bit wrap
  function automatic chan_t acc_step(input chan_t from_acc, input chan_t to_acc);
    chan_t       r;
    logic [15:0] diff;
    for (int ch = 0; ch < 3; ch++) begin
      diff  = to_acc[ch] - from_acc[ch];
      r[ch] = 16'($signed(diff) >>> 7);
    end
    return r;
  endfunction

  // accumulators back to the packed 15-bit colour: low bits on top, nibbles below
  function automatic logic [14:0] acc_to_colour(input chan_t v);
    return {v[2][10], v[1][10], v[0][10], v[2][14:11], v[1][14:11], v[0][14:11]};
  endfunction

  // advance the predictor by one accepted command word
  task automatic predict_fade(input in_word_t w);
    chan_t     a, b;
    out_word_t o;
    logic      done;
    case (w.op)
      OP_LOAD: begin
        if (w.entry_index < NUM_ENTRIES) begin
          a = colour_to_acc(w.current_colour);
          b = colour_to_acc(w.next_colour);
          acc_value[w.entry_index] = a;
          acc_incr[w.entry_index]  = acc_step(a, b);
          n_loads++;
        end
      end
      OP_START: begin
        fade_left = FADE_TICKS;
        n_starts++;
      end
      OP_TICK: begin
        // idle tick: nothing moves, nothing comes out
        if (fade_left != 0) begin
          fade_left = fade_left - 8'd1;
          done = (fade_left == 0);
          n_armed_ticks++;
          if (done) n_fades++;
          for (int e = 0; e < NUM_ENTRIES; e++) begin
            for (int ch = 0; ch < 3; ch++) begin
              acc_value[e][ch] = acc_value[e][ch] + acc_incr[e][ch];
            end
            o.out_index = IDX_W'(e);
            o.colour    = acc_to_colour(acc_value[e]);
            o.last      = (e == NUM_ENTRIES - 1);
            o.fade_done = done;
            faded_q.push_back(o);
          end
        end
      end
      default: ;
    endcase
  endtask

  task automatic report_mismatch(input string msg);
    $display("mismatch at %0t: %s", $realtime, msg);
    mismatches++;
  endtask

  task automatic check_word(input out_word_t got);
    out_word_t want;
    if (faded_q.size() == 0) begin
      report_mismatch($sformatf("word for entry %0d with nothing expected", got.out_index));
    end else begin
      want = faded_q.pop_front();
      n_words++;
      if (got.out_index !== want.out_index)
        report_mismatch($sformatf("out_index %0d, want %0d", got.out_index, want.out_index));
      if (got.colour !== want.colour)
        report_mismatch($sformatf("entry %0d colour %h, want %h",
                                  want.out_index, got.colour, want.colour));
      if (got.last !== want.last)
        report_mismatch($sformatf("entry %0d last %b, want %b",
                                  want.out_index, got.last, want.last));
      if (got.fade_done !== want.fade_done)
        report_mismatch($sformatf("entry %0d fade_done %b, want %b",
                                  want.out_index, got.fade_done, want.fade_done));
    end
  endtask

  // monitor: a word is taken when start is high and busy low at the rising edge;
  // the result strobe is sampled at the same edge
  always @(posedge clk) begin
    if (!rst_n) begin
      took = 1'b0;
    end else begin
      took = start && !busy;
      if (took) predict_fade(in_word);
      if (out_strobe) check_word(out_word);
    end
  end

  // driver: inputs move on the falling edge; a new word goes out only once the
  // previous one was taken, with random idle bursts except near the end
  always @(negedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else if (!start || took) begin
      if (gap_left != 0) begin
        gap_left <= gap_left - 1;
        start    <= 1'b0;
      end else if (cmd_q.size() > 40 && $urandom_range(0, 99) < idle_pct) begin
        gap_left <= $urandom_range(0, 14);
        start    <= 1'b0;
      end else if (cmd_q.size() != 0) begin
        in_word <= cmd_q.pop_front();
        start   <= 1'b1;
        // switch between bursty and back-to-back stretches
        if ($urandom_range(0, 24) == 0) idle_pct <= (idle_pct == 0) ? 20 : 0;
      end else begin
        start <= 1'b0;
      end
    end
  end

  task automatic queue_word(input logic [1:0] op, input int idx,
                            input logic [15:0] cur, input logic [15:0] nxt);
    in_word_t w;
    w.op             = op;
    w.entry_index    = IDX_W'(idx);
    w.current_colour = cur;
    w.next_colour    = nxt;
    cmd_q.push_back(w);
  endtask

  // mostly in-range entries, now and then an index past the table
  task automatic queue_random_load();
    int idx;
    if ($urandom_range(0, 99) < 88) idx = $urandom_range(0, NUM_ENTRIES - 1);
    else                            idx = $urandom_range(NUM_ENTRIES, 31);
    queue_word(OP_LOAD, idx, 16'($urandom), 16'($urandom));
  endtask

  // run out of time: something is stuck
  initial begin
    #3000000;
    $display("testbench NOT OK");
    $finish;
  end

  initial begin
    int r;

    // every entry is loaded before the first tick, so no tick ever reads
    // an entry that holds power-up garbage; extremes ride on the first few
    queue_word(OP_LOAD, 0, 16'h0000, 16'h7FFF);
    queue_word(OP_LOAD, 1, 16'h7FFF, 16'h0000);
    queue_word(OP_LOAD, 2, 16'hFFFF, 16'h8000);
    queue_word(OP_LOAD, 3, 16'h8000, 16'hFFFF);
    queue_word(OP_LOAD, 4, 16'h0F0F, 16'h70F0);
    for (int e = 5; e < NUM_ENTRIES; e++)
      queue_word(OP_LOAD, e, 16'($urandom), 16'($urandom));
    // loads past the table, unused op, idle tick: all ignored
    queue_word(OP_LOAD, NUM_ENTRIES, 16'hFFFF, 16'h0000);
    queue_word(OP_LOAD, 31, 16'h1234, 16'hFFFF);
    queue_word(OP_SPARE, 31, 16'hFFFF, 16'hFFFF);
    queue_word(OP_TICK, 0, 16'h0000, 16'h0000);
    // arm, tick, restart while armed, reload during the fade
    queue_word(OP_START, 0, 16'h0000, 16'h0000);
    queue_word(OP_TICK, 0, 16'h0000, 16'h0000);
    queue_word(OP_TICK, 31, 16'hFFFF, 16'hFFFF);
    queue_word(OP_START, 0, 16'h0000, 16'h0000);
    queue_word(OP_LOAD, 5, 16'h7FFF, 16'h0000);
    queue_word(OP_TICK, 0, 16'h0000, 16'h0000);
    queue_word(OP_TICK, 0, 16'h0000, 16'h0000);

    // one full fade to completion with loads sprinkled in, then idle ticks
    queue_word(OP_START, 0, 16'($urandom), 16'($urandom));
    for (int t = 0; t < 128; t++) begin
      if ($urandom_range(0, 99) < 8) queue_random_load();
      if ($urandom_range(0, 99) < 2) queue_word(OP_SPARE, $urandom_range(0, 31),
                                                16'($urandom), 16'($urandom));
      queue_word(OP_TICK, $urandom_range(0, 31), 16'($urandom), 16'($urandom));
    end
    for (int t = 0; t < 3; t++)
      queue_word(OP_TICK, 0, 16'($urandom), 16'($urandom));

    // mixed traffic: reloads, restarts, ticks and the odd unused op
    for (int k = 0; k < 100; k++) begin
      r = $urandom_range(0, 99);
      if (r < 35)      queue_random_load();
      else if (r < 42) queue_word(OP_START, $urandom_range(0, 31),
                                  16'($urandom), 16'($urandom));
      else if (r < 94) queue_word(OP_TICK, $urandom_range(0, 31),
                                  16'($urandom), 16'($urandom));
      else             queue_word(OP_SPARE, $urandom_range(0, 31),
                                  16'($urandom), 16'($urandom));
    end

    repeat (7) @(negedge clk);
    rst_n <= 1'b1;

    // all words handed over, then all results in, then a short drain
    while (cmd_q.size() != 0 || start) @(negedge clk);
    while (faded_q.size() != 0) @(negedge clk);
    repeat (30) @(negedge clk);

    if (faded_q.size() != 0)
      report_mismatch($sformatf("%0d words never arrived", faded_q.size()));

    $display("covered %0d loads, %0d starts, %0d armed ticks, %0d completed fades",
             n_loads, n_starts, n_armed_ticks, n_fades);
    $display("checked %0d faded colour words, %0d mismatches", n_words, mismatches);
    if (mismatches == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/core/pef_pkg.sv
rtl/core/pef_cell.sv
rtl/core/pef_fade_unit.sv
rtl/core/palette_entry_linear_fader.sv
sim/testbench.sv
